[design/gelu_tanh_activation_assert.svh]
// Assertion macros for the checker file of the activation block.
`ifndef GELU_TANH_ACTIVATION_ASSERT_SVH
`define GELU_TANH_ACTIVATION_ASSERT_SVH

// Checked only while the block is out of reset.
`define GELU_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GELU_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/gelu_pkg.sv]
`timescale 1ns / 1ps

package gelu_pkg;

    localparam int DATA_W       = 16;
    localparam int SERIES_TERMS = 9;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_in;
        logic                     last_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_out;
        logic                     last_out;
    } t_out;

    // Per-item data that rides alongside the arithmetic.
    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic                     last;
        logic                     neg;
        logic                     big;
        logic [5:0]               k;
    } t_side;

    // Q28 constants.
    localparam logic [28:0]        IONE    = 29'd268435456;
    localparam logic [23:0]        C_CUBIC = 24'd12003091;
    localparam logic signed [29:0] C_K     = 30'sd428361012;
    localparam logic [28:0]        C_LOG2E = 29'd387270501;
    localparam logic [27:0]        C_LN2   = 28'd186065279;

    // floor(2^33 / i), used to divide the series terms by i.
    localparam logic [SERIES_TERMS:1][33:0] RECIP_TAB = {
        34'd954437176,  34'd1073741824, 34'd1227133513,
        34'd1431655765, 34'd1717986918, 34'd2147483648,
        34'd2863311530, 34'd4294967296, 34'd8589934592
    };

endpackage

[design/gelu_tanh_activation.sv]
`timescale 1ns / 1ps

// GELU (tanh form) on signed Q4.12 elements.
// Input channel: i_in_valid / o_in_ready carry i_in_data (x_in, last_in).
// Output channel: o_out_valid / i_out_ready carry o_out_data (y_out, last_out).
// Each item gives one result; last_out is a copy of last_in.
// The pipeline has 66 register stages. One item enters per cycle while the
// output is not stalled; the longest parts are the nine series terms of the
// exponential (three stages each) and the 29 stage restoring divider, one
// quotient bit a stage.
// When the receiver holds i_out_ready low with a result waiting, the whole
// pipeline freezes and o_in_ready drops in the same cycle; nothing is lost.
// Empty slots in the pipeline keep moving while the output waits only if the
// output stage itself is empty.
// Synchronous reset (i_rst_n low) clears every valid bit; data is not reset.
module gelu_tanh_activation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gelu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gelu_pkg::t_out o_out_data
);

    localparam int NT    = gelu_pkg::SERIES_TERMS;
    localparam int ST_H  = 7 + 3 * NT;   // last series stage
    localparam int ST_D0 = ST_H + 1;
    localparam int DQ    = 29;           // quotient bits
    localparam int ST_DN = ST_D0 + DQ;
    localparam int N     = ST_DN + 2;

    logic         en;
    logic         r_v [1:N];
    gelu_pkg::t_side r_sd [1:N];

    assign en          = !r_v[N] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= N; j++) r_v[j] <= 1'b0;
        end else if (en) begin
            r_v[1] <= i_in_valid;
            for (int j = 2; j <= N; j++) r_v[j] <= r_v[j-1];
        end
    end

    // Stages 2 to 7: polynomial argument, then exponent split.
    logic signed [31:0] w_sq;
    logic signed [45:0] w_ka;
    logic [54:0]        w_cub;
    logic signed [65:0] w_ap;
    logic signed [37:0] w_m;
    logic [61:0]        w_w;
    logic [55:0]        w_ul;

    logic [30:0]        r_s2_sq;
    logic signed [33:0] r_s2_a;
    logic [30:0]        r_s3_p;
    logic signed [33:0] r_s3_a;
    logic signed [37:0] r_s4_t;
    logic [32:0]        r_s5_m;
    logic [27:0]        r_s6_f;
    logic [27:0]        r_s7_u;

    assign w_sq  = r_sd[1].z * r_sd[1].z;
    assign w_ka  = r_sd[1].z * gelu_pkg::C_K;
    assign w_cub = r_s2_sq * gelu_pkg::C_CUBIC;
    assign w_ap  = r_s3_a * $signed({1'b0, r_s3_p});
    assign w_m   = r_s4_t[37] ? -r_s4_t : r_s4_t;
    assign w_w   = r_s5_m * gelu_pkg::C_LOG2E;
    assign w_ul  = r_s6_f * gelu_pkg::C_LN2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[1] <= '{z: i_in_data.x_in, last: i_in_data.last_in,
                         neg: 1'b0, big: 1'b0, k: 6'd0};
            for (int j = 2; j <= N; j++) begin
                if (j != 5 && j != 6) begin
                    r_sd[j] <= r_sd[j-1];
                end
            end
            // The sign and range of t join the item at stage 5, the shift at stage 6.
            r_sd[5] <= '{z: r_sd[4].z, last: r_sd[4].last, neg: r_s4_t[37],
                         big: |w_m[37:33], k: r_sd[4].k};
            r_sd[6] <= '{z: r_sd[5].z, last: r_sd[5].last, neg: r_sd[5].neg,
                         big: r_sd[5].big, k: w_w[61:56]};

            r_s2_sq <= w_sq[30:0];
            r_s2_a  <= w_ka[45:12];
            r_s3_p  <= {2'b00, gelu_pkg::IONE} + w_cub[54:24];
            r_s3_a  <= r_s2_a;
            r_s4_t  <= w_ap[65:28];
            r_s5_m  <= w_m[32:0];
            r_s6_f  <= w_w[55:28];
            r_s7_u  <= w_ul[55:28];
        end
    end

    // Series for exp(-u): r = 1 - u*r/i for i from NT down to 1.
    logic [27:0] w_hu [0:NT];
    logic [28:0] w_hr [0:NT];

    assign w_hu[0] = r_s7_u;
    assign w_hr[0] = gelu_pkg::IONE;

    for (genvar g = 0; g < NT; g++) begin : g_term
        localparam logic [3:0]  DIVC = 4'(NT - g);
        localparam logic [33:0] RCP  = gelu_pkg::RECIP_TAB[NT - g];

        logic [56:0] w_pa;
        logic [62:0] w_pb;
        logic [32:0] w_qi;
        logic [32:0] w_rm;
        logic [28:0] w_q;
        logic [28:0] r_a_pr;
        logic [27:0] r_a_u;
        logic [28:0] r_b_q;
        logic [28:0] r_b_pr;
        logic [27:0] r_b_u;
        logic [28:0] r_c_r;
        logic [27:0] r_c_u;

        assign w_pa = w_hu[g] * w_hr[g];
        assign w_pb = r_a_pr * RCP;
        assign w_qi = r_b_q * DIVC;
        assign w_rm = {4'd0, r_b_pr} - w_qi;
        // The reciprocal product is low by at most one.
        assign w_q  = r_b_q + {28'd0, (w_rm >= {29'd0, DIVC})};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_pr <= w_pa[56:28];
                r_a_u  <= w_hu[g];
                r_b_q  <= w_pb[61:33];
                r_b_pr <= r_a_pr;
                r_b_u  <= r_a_u;
                r_c_r  <= gelu_pkg::IONE - w_q;
                r_c_u  <= r_b_u;
            end
        end

        assign w_hu[g+1] = r_c_u;
        assign w_hr[g+1] = r_c_r;
    end

    // Sigmoid numerator and denominator.
    logic [28:0] w_e;
    logic [29:0] w_den;
    logic [57:0] w_num;

    always_comb begin
        if (r_sd[ST_H].big || r_sd[ST_H].k >= 6'd29) begin
            w_e = '0;
        end else begin
            w_e = w_hr[NT] >> r_sd[ST_H].k;
        end
        w_den = {1'b0, gelu_pkg::IONE} + {1'b0, w_e};
        if (r_sd[ST_H].neg) begin
            w_num = {1'b0, w_e, 28'd0} + {29'd0, w_den[29:1]};
        end else begin
            w_num = (58'd1 << 56) + {29'd0, w_den[29:1]};
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [29:0]   r_dv_rem [0:DQ];
    logic [DQ-1:0] r_dv_low [0:DQ];
    logic [DQ-1:0] r_dv_q   [0:DQ];
    logic [29:0]   r_dv_den [0:DQ];
    logic [30:0]   w_rem2   [1:DQ];
    logic          w_ge     [1:DQ];

    always_comb begin
        for (int j = 1; j <= DQ; j++) begin
            w_rem2[j] = {r_dv_rem[j-1], r_dv_low[j-1][DQ-1]};
            w_ge[j]   = w_rem2[j] >= {1'b0, r_dv_den[j-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0] <= {1'b0, w_num[57:29]};
            r_dv_low[0] <= w_num[28:0];
            r_dv_q[0]   <= '0;
            r_dv_den[0] <= w_den;
            for (int j = 1; j <= DQ; j++) begin
                r_dv_rem[j] <= w_ge[j] ? 30'(w_rem2[j] - {1'b0, r_dv_den[j-1]})
                                       : w_rem2[j][29:0];
                r_dv_low[j] <= r_dv_low[j-1] << 1;
                r_dv_q[j]   <= {r_dv_q[j-1][DQ-2:0], w_ge[j]};
                r_dv_den[j] <= r_dv_den[j-1];
            end
        end
    end

    // Scale the input by the sigmoid, round half up, saturate.
    logic signed [45:0] w_ys;
    logic signed [17:0] r_m_y;
    logic signed [15:0] r_o_y;

    assign w_ys = r_sd[ST_DN].z * $signed({1'b0, r_dv_q[DQ]}) + 46'sd134217728;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_y <= w_ys[45:28];
            if (r_m_y > 18'sd32767) begin
                r_o_y <= 16'sh7fff;
            end else if (r_m_y < -18'sd32768) begin
                r_o_y <= 16'sh8000;
            end else begin
                r_o_y <= r_m_y[15:0];
            end
        end
    end

    assign o_out_data.y_out    = r_o_y;
    assign o_out_data.last_out = r_sd[N].last;

endmodule

[design/gelu_chk.sv]
`timescale 1ns / 1ps

`include "gelu_tanh_activation_assert.svh"

module gelu_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input gelu_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input gelu_pkg::t_out o_out_data
);

    // No result may appear in the cycle after a reset edge.
    `GELU_ASSERT_ALL(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // The pipeline takes an item exactly when its last stage can move.
    `GELU_ASSERT_RUN(a_ready_rule, o_in_ready == (!o_out_valid || i_out_ready), "ready mismatch")

    `GELU_ASSERT_RUN(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled item changed")

endmodule

bind gelu_tanh_activation gelu_chk u_chk (.*);
